[hdl/adc_sss_pkg.sv]
// Shared constants and types for the converter sample conditioning block.
// Holds field widths, register reset values, register indexes and derived
// datapath widths. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package adc_sss_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 12;
    localparam int MV_BITS = 14;
    localparam int ANG_BITS = 10;

    // Configuration port.
    localparam int CFG_DATA_BITS = (SAMPLE_BITS > MV_BITS) ? SAMPLE_BITS : MV_BITS;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ADC_LOW    = CFG_INDEX_BITS'(0),
        REG_ADC_HIGH   = CFG_INDEX_BITS'(1),
        REG_SPIKE_THR  = CFG_INDEX_BITS'(2),
        REG_MV_LOW     = CFG_INDEX_BITS'(3),
        REG_MV_HIGH    = CFG_INDEX_BITS'(4),
        REG_ANG_LOW    = CFG_INDEX_BITS'(5),
        REG_ANG_HIGH   = CFG_INDEX_BITS'(6)
    } cfg_index_t;

    // Register reset values.
    localparam logic [SAMPLE_BITS-1:0] ADC_LOW_RESET = '0;
    localparam logic [SAMPLE_BITS-1:0] ADC_HIGH_RESET = SAMPLE_BITS'(4095);
    localparam logic [SAMPLE_BITS-1:0] SPIKE_THR_RESET = SAMPLE_BITS'(100);
    localparam logic [MV_BITS-1:0] MV_LOW_RESET = '0;
    localparam logic [MV_BITS-1:0] MV_HIGH_RESET = MV_BITS'(5000);
    localparam logic signed [ANG_BITS-1:0] ANG_LOW_RESET = '0;
    localparam logic signed [ANG_BITS-1:0] ANG_HIGH_RESET = ANG_BITS'(270);

    // Weighted sum of three codes with weights 1, 2 and 3.
    localparam int WSUM_BITS = SAMPLE_BITS + 3;

    // Division by six as a multiplication by a rounded-up reciprocal. The
    // extra shift keeps the error below one sixth over the whole sum range.
    localparam int RECIP_SHIFT = WSUM_BITS + 3;
    localparam int RECIP_BITS = RECIP_SHIFT - 2;
    localparam logic [RECIP_BITS-1:0] RECIP_SIX =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);

    // Signed width that holds every map operand, and their differences.
    localparam int MAP_BITS = CFG_DATA_BITS + 1;
    localparam int DIFF_BITS = MAP_BITS + 1;

    // Shared multiplier operand widths.
    localparam int MUL_A_BITS = (WSUM_BITS + 1 > DIFF_BITS) ? WSUM_BITS + 1 : DIFF_BITS;
    localparam int MUL_B_BITS = (RECIP_BITS + 1 > DIFF_BITS) ? RECIP_BITS + 1 : DIFF_BITS;
    localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS;

    // Serial divider: dividend magnitude and divisor widths.
    localparam int NUM_BITS = ((SAMPLE_BITS > ANG_BITS) ? SAMPLE_BITS : ANG_BITS) + MV_BITS;
    localparam int DEN_BITS = CFG_DATA_BITS;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
    localparam int SUM_BITS = NUM_BITS + 2;

endpackage

`default_nettype wire

[hdl/adc_spike_smooth_scale.sv]
// Converter sample conditioning: clamp, spike rejection, 1:2:3 smoothing, and two
// linear maps to millivolts and degrees; uses adc_sss_pkg. The result is computed
// through two passes of the one-bit-per-cycle divider; a new sample is taken only
// once the previous result has been loaded into the output register.
// Asynchronous active-low reset restores register defaults and clears the histories.
// No clearing pass is needed: the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module adc_spike_smooth_scale (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    // Configuration writes.
    input  wire logic                                         cfg_write,
    input  wire logic [adc_sss_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  wire logic [adc_sss_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    // Sample channel.
    input  wire logic                                         sample_valid,
    output      logic                                         sample_ready,
    input  wire logic [adc_sss_pkg::SAMPLE_BITS-1:0]          sample,
    // Result channel.
    output      logic                                         result_valid,
    input  wire logic                                         result_ready,
    output      logic [adc_sss_pkg::SAMPLE_BITS-1:0]          despiked,
    output      logic [adc_sss_pkg::SAMPLE_BITS-1:0]          smoothed,
    output      logic [adc_sss_pkg::MV_BITS-1:0]              millivolts,
    output      logic signed [adc_sss_pkg::ANG_BITS-1:0]      angle
);

    // Sequencer. Every sample walks the same path: spike test, division by six
    // through the shared multiplier, then the linear map twice (pass 0 gives
    // millivolts, pass 1 gives degrees). Each map pass is a multiply, a sign
    // and magnitude split, a restoring divide of NUM_BITS steps, and a final
    // add and clamp.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_SPIKE  = 9'b0_0000_0010,
        ST_RECIP  = 9'b0_0000_0100,
        ST_SMOOTH = 9'b0_0000_1000,
        ST_MUL    = 9'b0_0001_0000,
        ST_PREP   = 9'b0_0010_0000,
        ST_DIV    = 9'b0_0100_0000,
        ST_MAP    = 9'b0_1000_0000,
        ST_DONE   = 9'b1_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] adc_low_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] adc_high_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] spike_thr_reg;
    logic [adc_sss_pkg::MV_BITS-1:0] mv_low_reg;
    logic [adc_sss_pkg::MV_BITS-1:0] mv_high_reg;
    logic signed [adc_sss_pkg::ANG_BITS-1:0] ang_low_reg;
    logic signed [adc_sss_pkg::ANG_BITS-1:0] ang_high_reg;

    // Histories of clamped raw codes and despiked codes.
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] raw_older_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] raw_newer_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] desp_older_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] desp_newer_reg;
    logic primed_reg;

    // Working registers of the current sample.
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] raw_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] desp_reg;
    logic [adc_sss_pkg::WSUM_BITS-1:0] wsum_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] smooth_reg;
    logic [adc_sss_pkg::MV_BITS-1:0] mv_reg;
    logic signed [adc_sss_pkg::ANG_BITS-1:0] ang_reg;
    logic pass_reg;

    // Shared multiplier product and divider state.
    logic signed [adc_sss_pkg::PROD_BITS-1:0] prod_reg;
    logic [adc_sss_pkg::NUM_BITS-1:0] quot_reg;
    logic [adc_sss_pkg::DEN_BITS-1:0] rem_reg;
    logic [adc_sss_pkg::DEN_BITS-1:0] den_reg;
    logic [adc_sss_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic neg_reg;
    logic zero_span_reg;

    // Output register.
    logic result_valid_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] despiked_out_reg;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] smoothed_out_reg;
    logic [adc_sss_pkg::MV_BITS-1:0] millivolts_out_reg;
    logic signed [adc_sss_pkg::ANG_BITS-1:0] angle_out_reg;

    function automatic logic [adc_sss_pkg::SAMPLE_BITS-1:0] abs_diff(
        input logic [adc_sss_pkg::SAMPLE_BITS-1:0] a,
        input logic [adc_sss_pkg::SAMPLE_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // ------------------------------------------------------------------
    // Configuration register file. Writes are to arrive only while idle; the
    // block does not enforce it; the datapath reads these registers directly.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_low_reg   <= adc_sss_pkg::ADC_LOW_RESET;
            adc_high_reg  <= adc_sss_pkg::ADC_HIGH_RESET;
            spike_thr_reg <= adc_sss_pkg::SPIKE_THR_RESET;
            mv_low_reg    <= adc_sss_pkg::MV_LOW_RESET;
            mv_high_reg   <= adc_sss_pkg::MV_HIGH_RESET;
            ang_low_reg   <= adc_sss_pkg::ANG_LOW_RESET;
            ang_high_reg  <= adc_sss_pkg::ANG_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (adc_sss_pkg::cfg_index_t'(cfg_index))
                adc_sss_pkg::REG_ADC_LOW:
                    adc_low_reg <= cfg_data[adc_sss_pkg::SAMPLE_BITS-1:0];
                adc_sss_pkg::REG_ADC_HIGH:
                    adc_high_reg <= cfg_data[adc_sss_pkg::SAMPLE_BITS-1:0];
                adc_sss_pkg::REG_SPIKE_THR:
                    spike_thr_reg <= cfg_data[adc_sss_pkg::SAMPLE_BITS-1:0];
                adc_sss_pkg::REG_MV_LOW:
                    mv_low_reg <= cfg_data[adc_sss_pkg::MV_BITS-1:0];
                adc_sss_pkg::REG_MV_HIGH:
                    mv_high_reg <= cfg_data[adc_sss_pkg::MV_BITS-1:0];
                adc_sss_pkg::REG_ANG_LOW:
                    ang_low_reg <= cfg_data[adc_sss_pkg::ANG_BITS-1:0];
                adc_sss_pkg::REG_ANG_HIGH:
                    ang_high_reg <= cfg_data[adc_sss_pkg::ANG_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input clamp. The low limit is tested first, so inverted limits always
    // give one of the two limits.
    // ------------------------------------------------------------------
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] raw_clamped;

    always_comb
    begin
        if (sample < adc_low_reg)
            raw_clamped = adc_low_reg;
        else if (sample > adc_high_reg)
            raw_clamped = adc_high_reg;
        else
            raw_clamped = sample;
    end

    // ------------------------------------------------------------------
    // Spike test and weighted sum. Before the first sample the histories are
    // unprimed, and every history value is replaced by the current code; the
    // spike test can then never fire.
    // ------------------------------------------------------------------
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] hist_r1;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] hist_r2;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] hist_d1;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] hist_d2;
    logic [adc_sss_pkg::SAMPLE_BITS:0] pair_sum;
    logic is_spike;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] desp_calc;
    logic [adc_sss_pkg::WSUM_BITS-1:0] desp_wide;
    logic [adc_sss_pkg::WSUM_BITS-1:0] wsum_calc;

    always_comb
    begin
        hist_r1 = primed_reg ? raw_newer_reg : raw_reg;
        hist_r2 = primed_reg ? raw_older_reg : raw_reg;
        hist_d1 = primed_reg ? desp_newer_reg : raw_reg;
        hist_d2 = primed_reg ? desp_older_reg : raw_reg;

        is_spike = (abs_diff(raw_reg, hist_r1) > spike_thr_reg)
                && (abs_diff(raw_reg, hist_r2) > spike_thr_reg)
                && (abs_diff(hist_r1, hist_r2) < spike_thr_reg);

        pair_sum = {1'b0, hist_r1} + {1'b0, hist_r2};
        desp_calc = is_spike ? pair_sum[adc_sss_pkg::SAMPLE_BITS:1] : raw_reg;

        desp_wide = adc_sss_pkg::WSUM_BITS'(desp_calc);
        wsum_calc = adc_sss_pkg::WSUM_BITS'(hist_d2)
                  + (adc_sss_pkg::WSUM_BITS'(hist_d1) << 1)
                  + (desp_wide << 1) + desp_wide;
    end

    // ------------------------------------------------------------------
    // Linear map operands. Pass 0 maps the smoothed code to millivolts,
    // pass 1 maps millivolts to degrees. All operands are brought to one
    // signed width so a single datapath serves both passes.
    // ------------------------------------------------------------------
    logic signed [adc_sss_pkg::MAP_BITS-1:0] map_x;
    logic signed [adc_sss_pkg::MAP_BITS-1:0] map_in_lo;
    logic signed [adc_sss_pkg::MAP_BITS-1:0] map_in_hi;
    logic signed [adc_sss_pkg::MAP_BITS-1:0] map_out_lo;
    logic signed [adc_sss_pkg::MAP_BITS-1:0] map_out_hi;
    logic signed [adc_sss_pkg::DIFF_BITS-1:0] x_diff;
    logic signed [adc_sss_pkg::DIFF_BITS-1:0] in_span;
    logic signed [adc_sss_pkg::DIFF_BITS-1:0] out_span;

    always_comb
    begin
        if (!pass_reg)
        begin
            map_x      = signed'(adc_sss_pkg::MAP_BITS'(smooth_reg));
            map_in_lo  = signed'(adc_sss_pkg::MAP_BITS'(adc_low_reg));
            map_in_hi  = signed'(adc_sss_pkg::MAP_BITS'(adc_high_reg));
            map_out_lo = signed'(adc_sss_pkg::MAP_BITS'(mv_low_reg));
            map_out_hi = signed'(adc_sss_pkg::MAP_BITS'(mv_high_reg));
        end
        else
        begin
            map_x      = signed'(adc_sss_pkg::MAP_BITS'(mv_reg));
            map_in_lo  = signed'(adc_sss_pkg::MAP_BITS'(mv_low_reg));
            map_in_hi  = signed'(adc_sss_pkg::MAP_BITS'(mv_high_reg));
            map_out_lo = adc_sss_pkg::MAP_BITS'(ang_low_reg);
            map_out_hi = adc_sss_pkg::MAP_BITS'(ang_high_reg);
        end

        x_diff   = adc_sss_pkg::DIFF_BITS'(map_x) - adc_sss_pkg::DIFF_BITS'(map_in_lo);
        in_span  = adc_sss_pkg::DIFF_BITS'(map_in_hi) - adc_sss_pkg::DIFF_BITS'(map_in_lo);
        out_span = adc_sss_pkg::DIFF_BITS'(map_out_hi) - adc_sss_pkg::DIFF_BITS'(map_out_lo);
    end

    // ------------------------------------------------------------------
    // Shared multiplier: the reciprocal of six in one step, the map product
    // in each map pass.
    // ------------------------------------------------------------------
    logic signed [adc_sss_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [adc_sss_pkg::MUL_B_BITS-1:0] mul_b;

    always_comb
    begin
        if (state_reg == ST_RECIP)
        begin
            mul_a = signed'(adc_sss_pkg::MUL_A_BITS'(wsum_reg));
            mul_b = signed'(adc_sss_pkg::MUL_B_BITS'(adc_sss_pkg::RECIP_SIX));
        end
        else
        begin
            mul_a = adc_sss_pkg::MUL_A_BITS'(x_diff);
            mul_b = adc_sss_pkg::MUL_B_BITS'(out_span);
        end
    end

    // Weighted mean after the reciprocal multiply, clamped to the converter limits.
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] wmean;
    logic [adc_sss_pkg::SAMPLE_BITS-1:0] smooth_calc;

    always_comb
    begin
        wmean = prod_reg[adc_sss_pkg::RECIP_SHIFT +: adc_sss_pkg::SAMPLE_BITS];
        if (wmean < adc_low_reg)
            smooth_calc = adc_low_reg;
        else if (wmean > adc_high_reg)
            smooth_calc = adc_high_reg;
        else
            smooth_calc = wmean;
    end

    // ------------------------------------------------------------------
    // Divider setup: the product and the input span are split into sign and
    // magnitude, so the restoring divider works on magnitudes and the
    // quotient truncates toward zero.
    // ------------------------------------------------------------------
    logic [adc_sss_pkg::PROD_BITS-1:0] prod_abs;
    logic [adc_sss_pkg::DIFF_BITS-1:0] span_abs;

    always_comb
    begin
        prod_abs = prod_reg[adc_sss_pkg::PROD_BITS-1]
                 ? (~prod_reg + 1'b1) : prod_reg;
        span_abs = in_span[adc_sss_pkg::DIFF_BITS-1]
                 ? (~in_span + 1'b1) : in_span;
    end

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    logic [adc_sss_pkg::DEN_BITS:0] div_shifted;
    logic div_fits;
    logic [adc_sss_pkg::DEN_BITS:0] div_diff;

    always_comb
    begin
        div_shifted = {rem_reg, quot_reg[adc_sss_pkg::NUM_BITS-1]};
        div_fits = div_shifted >= {1'b0, den_reg};
        div_diff = div_shifted - {1'b0, den_reg};
    end

    // Map end: signed quotient added to the output origin, then clamped.
    logic signed [adc_sss_pkg::SUM_BITS-1:0] quot_ext;
    logic signed [adc_sss_pkg::SUM_BITS-1:0] quot_signed;
    logic signed [adc_sss_pkg::SUM_BITS-1:0] out_lo_ext;
    logic signed [adc_sss_pkg::SUM_BITS-1:0] out_hi_ext;
    logic signed [adc_sss_pkg::SUM_BITS-1:0] map_sum;
    logic signed [adc_sss_pkg::SUM_BITS-1:0] map_clamped;
    logic [adc_sss_pkg::MAP_BITS-1:0] map_result;

    always_comb
    begin
        quot_ext = signed'(adc_sss_pkg::SUM_BITS'(quot_reg));
        quot_signed = neg_reg ? -quot_ext : quot_ext;
        out_lo_ext = adc_sss_pkg::SUM_BITS'(map_out_lo);
        out_hi_ext = adc_sss_pkg::SUM_BITS'(map_out_hi);
        // A zero input span answers the output origin.
        map_sum = zero_span_reg ? out_lo_ext : (out_lo_ext + quot_signed);
        if (map_sum < out_lo_ext)
            map_clamped = out_lo_ext;
        else if (map_sum > out_hi_ext)
            map_clamped = out_hi_ext;
        else
            map_clamped = map_sum;
        map_result = map_clamped[adc_sss_pkg::MAP_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (sample_valid)
                    state_next = ST_SPIKE;
            ST_SPIKE:
                state_next = ST_RECIP;
            ST_RECIP:
                state_next = ST_SMOOTH;
            ST_SMOOTH:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_PREP;
            ST_PREP:
                state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == adc_sss_pkg::DIV_CNT_BITS'(1))
                    state_next = ST_MAP;
            ST_MAP:
                state_next = pass_reg ? ST_DONE : ST_MUL;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state, histories and the result flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            primed_reg       <= 1'b0;
            raw_older_reg    <= '0;
            raw_newer_reg    <= '0;
            desp_older_reg   <= '0;
            desp_newer_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            // Histories advance once per sample, after the spike test.
            if (state_reg == ST_SPIKE)
            begin
                primed_reg     <= 1'b1;
                raw_older_reg  <= hist_r1;
                raw_newer_reg  <= raw_reg;
                desp_older_reg <= hist_d1;
                desp_newer_reg <= desp_calc;
            end
        end
    end

    // Datapath registers; each is written before it is read for a sample.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (sample_valid)
                    raw_reg <= raw_clamped;
            ST_SPIKE:
            begin
                desp_reg <= desp_calc;
                wsum_reg <= wsum_calc;
            end
            ST_RECIP:
                prod_reg <= mul_a * mul_b;
            ST_SMOOTH:
            begin
                smooth_reg <= smooth_calc;
                pass_reg   <= 1'b0;
            end
            ST_MUL:
                prod_reg <= mul_a * mul_b;
            ST_PREP:
            begin
                quot_reg      <= prod_abs[adc_sss_pkg::NUM_BITS-1:0];
                rem_reg       <= '0;
                den_reg       <= span_abs[adc_sss_pkg::DEN_BITS-1:0];
                neg_reg       <= prod_reg[adc_sss_pkg::PROD_BITS-1]
                               ^ in_span[adc_sss_pkg::DIFF_BITS-1];
                zero_span_reg <= (in_span == '0);
                cnt_reg       <= adc_sss_pkg::DIV_CNT_BITS'(adc_sss_pkg::NUM_BITS);
            end
            ST_DIV:
            begin
                rem_reg  <= div_fits ? div_diff[adc_sss_pkg::DEN_BITS-1:0]
                                     : div_shifted[adc_sss_pkg::DEN_BITS-1:0];
                quot_reg <= {quot_reg[adc_sss_pkg::NUM_BITS-2:0], div_fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            ST_MAP:
            begin
                if (!pass_reg)
                    mv_reg <= map_result[adc_sss_pkg::MV_BITS-1:0];
                else
                    ang_reg <= map_result[adc_sss_pkg::ANG_BITS-1:0];
                pass_reg <= 1'b1;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: loaded when the previous result has been taken, so a
    // finished result never blocks the input side for longer than needed.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            despiked_out_reg   <= desp_reg;
            smoothed_out_reg   <= smooth_reg;
            millivolts_out_reg <= mv_reg;
            angle_out_reg      <= ang_reg;
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign despiked     = despiked_out_reg;
    assign smoothed     = smoothed_out_reg;
    assign millivolts   = millivolts_out_reg;
    assign angle        = angle_out_reg;

endmodule

`default_nettype wire

[hdl/adc_sss_checker.sv]
// Port-level checks for the converter sample conditioning block, bound to
// adc_spike_smooth_scale; uses adc_sss_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module adc_sss_checker (
    input wire logic                                      clk,
    input wire logic                                      rst_n,
    input wire logic                                      sample_valid,
    input wire logic                                      sample_ready,
    input wire logic                                      result_valid,
    input wire logic                                      result_ready,
    input wire logic [adc_sss_pkg::SAMPLE_BITS-1:0]       despiked,
    input wire logic [adc_sss_pkg::SAMPLE_BITS-1:0]       smoothed,
    input wire logic [adc_sss_pkg::MV_BITS-1:0]           millivolts,
    input wire logic signed [adc_sss_pkg::ANG_BITS-1:0]   angle
);

    // Reset empties the output register.
    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid while in reset");

    // A sample transfer starts a multi-cycle computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready ##1 !sample_ready)
        else $error("sample accepted again right after a transfer");

    // A new result appears only at the end of a busy stretch.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result appeared without a computation in flight");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid && $stable(despiked)
            && $stable(smoothed) && $stable(millivolts) && $stable(angle))
        else $error("stalled result changed");

endmodule

bind adc_spike_smooth_scale adc_sss_checker u_adc_sss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .despiked     (despiked),
    .smoothed     (smoothed),
    .millivolts   (millivolts),
    .angle        (angle)
);

`default_nettype wire

[tb/adc_sss_reading_checker.sv]
`timescale 1ns / 1ps
// Reading checker for the converter sample conditioning block: follows register
// writes, predicts one reading per accepted sample and compares every result.
// Depends on adc_sss_pkg for widths, register indexes and reset values.

module adc_sss_reading_checker
    import adc_sss_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          sample_valid,
    input  wire logic                          sample_ready,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic                          result_valid,
    input  wire logic                          result_ready,
    input  wire logic [SAMPLE_BITS-1:0]        despiked,
    input  wire logic [SAMPLE_BITS-1:0]        smoothed,
    input  wire logic [MV_BITS-1:0]            millivolts,
    input  wire logic signed [ANG_BITS-1:0]    angle,
    output int                                 mismatches,
    output int                                 readings_pending
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]     despiked;
        logic [SAMPLE_BITS-1:0]     smoothed;
        logic [MV_BITS-1:0]         millivolts;
        logic signed [ANG_BITS-1:0] angle;
    } reading_t;

    reading_t expected_readings[$];

    // Shadow copy of the register file.
    logic [SAMPLE_BITS-1:0]     adc_lo;
    logic [SAMPLE_BITS-1:0]     adc_hi;
    logic [SAMPLE_BITS-1:0]     spike_thr;
    logic [MV_BITS-1:0]         mv_lo;
    logic [MV_BITS-1:0]         mv_hi;
    logic signed [ANG_BITS-1:0] ang_lo;
    logic signed [ANG_BITS-1:0] ang_hi;

    // Sample histories.
    logic [SAMPLE_BITS-1:0]     raw_older;
    logic [SAMPLE_BITS-1:0]     raw_newer;
    logic [SAMPLE_BITS-1:0]     desp_older;
    logic [SAMPLE_BITS-1:0]     desp_newer;
    logic                       primed;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Straight-line map; a zero input span answers the output origin.
    function automatic longint scale_linear(longint x, longint in_lo, longint in_hi,
                                            longint out_lo, longint out_hi);
        longint span;
        span = in_hi - in_lo;
        if (span == 0)
            return out_lo;
        return out_lo + (x - in_lo) * (out_hi - out_lo) / span;
    endfunction

    function automatic longint distance(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        reading_t want;
        longint   code;
        longint   thr;
        longint   filtered;
        longint   weighted;
        longint   smooth;
        longint   mv;
        longint   deg;
        if (!rst_n)
        begin
            adc_lo = ADC_LOW_RESET;
            adc_hi = ADC_HIGH_RESET;
            spike_thr = SPIKE_THR_RESET;
            mv_lo = MV_LOW_RESET;
            mv_hi = MV_HIGH_RESET;
            ang_lo = ANG_LOW_RESET;
            ang_hi = ANG_HIGH_RESET;
            raw_older = '0;
            raw_newer = '0;
            desp_older = '0;
            desp_newer = '0;
            primed = 1'b0;
            expected_readings.delete();
            mismatches = 0;
            readings_pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_ADC_LOW:   adc_lo = cfg_data[SAMPLE_BITS-1:0];
                    REG_ADC_HIGH:  adc_hi = cfg_data[SAMPLE_BITS-1:0];
                    REG_SPIKE_THR: spike_thr = cfg_data[SAMPLE_BITS-1:0];
                    REG_MV_LOW:    mv_lo = cfg_data[MV_BITS-1:0];
                    REG_MV_HIGH:   mv_hi = cfg_data[MV_BITS-1:0];
                    REG_ANG_LOW:   ang_lo = cfg_data[ANG_BITS-1:0];
                    REG_ANG_HIGH:  ang_hi = cfg_data[ANG_BITS-1:0];
                    default: ;
                endcase
            end

            if (sample_valid && sample_ready)
            begin
                code = clamp_to(sample, adc_lo, adc_hi);
                thr = spike_thr;
                // The first sample after reset fills both histories.
                if (!primed)
                begin
                    raw_older = SAMPLE_BITS'(code);
                    raw_newer = SAMPLE_BITS'(code);
                    desp_older = SAMPLE_BITS'(code);
                    desp_newer = SAMPLE_BITS'(code);
                    primed = 1'b1;
                end
                filtered = code;
                if (distance(code, raw_newer) > thr && distance(code, raw_older) > thr
                        && distance(raw_newer, raw_older) < thr)
                    filtered = (longint'(raw_newer) + longint'(raw_older)) / 2;
                weighted = (longint'(desp_older) + 2 * longint'(desp_newer)
                            + 3 * filtered) / 6;
                smooth = clamp_to(weighted, adc_lo, adc_hi);
                mv = clamp_to(scale_linear(smooth, adc_lo, adc_hi, mv_lo, mv_hi),
                              mv_lo, mv_hi);
                deg = clamp_to(scale_linear(mv, mv_lo, mv_hi, ang_lo, ang_hi),
                               ang_lo, ang_hi);

                raw_older = raw_newer;
                raw_newer = SAMPLE_BITS'(code);
                desp_older = desp_newer;
                desp_newer = SAMPLE_BITS'(filtered);

                want.despiked = SAMPLE_BITS'(filtered);
                want.smoothed = SAMPLE_BITS'(smooth);
                want.millivolts = MV_BITS'(mv);
                want.angle = ANG_BITS'(deg);
                expected_readings.push_back(want);
            end

            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("result transfer with no reading outstanding");
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (despiked !== want.despiked)
                        report_mismatch($sformatf("despiked: got %0d, expected %0d",
                                                  despiked, want.despiked));
                    if (smoothed !== want.smoothed)
                        report_mismatch($sformatf("smoothed: got %0d, expected %0d",
                                                  smoothed, want.smoothed));
                    if (millivolts !== want.millivolts)
                        report_mismatch($sformatf("millivolts: got %0d, expected %0d",
                                                  millivolts, want.millivolts));
                    if (angle !== want.angle)
                        report_mismatch($sformatf("angle: got %0d, expected %0d",
                                                  angle, want.angle));
                end
            end

            readings_pending <= expected_readings.size();
        end
    end

endmodule

[tb/adc_spike_smooth_scale_tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for adc_spike_smooth_scale: clock, reset, register
// programming, sample stimulus and result back-pressure, and the final verdict.
// Depends on adc_sss_pkg, the block itself and adc_sss_reading_checker.

module adc_spike_smooth_scale_tb;
    import adc_sss_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 9;
    // Twelve register settings of 86 samples each, after a short directed run.
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 86;
    // The receiver stops once for a long stretch after this many sample transfers.
    localparam int LONG_HOLD_AT = 200;
    localparam int LONG_HOLD_CYCLES = 600;
    // Settle wait after the last reading; leave some margin.
    localparam int SETTLE_CYCLES = 80;
    // The slowest legal run, the long hold included, stays well inside this limit.
    localparam int CYCLE_LIMIT = 400000;
    localparam int CODE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int MV_MAX = 10000;
    localparam int ANG_LIMIT = 360;
    // Index that no register answers to; a write there must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = '1;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;
    logic                       sample_valid;
    logic                       sample_ready;
    logic [SAMPLE_BITS-1:0]     sample;
    logic                       result_valid;
    logic                       result_ready;
    logic [SAMPLE_BITS-1:0]     despiked;
    logic [SAMPLE_BITS-1:0]     smoothed;
    logic [MV_BITS-1:0]         millivolts;
    logic signed [ANG_BITS-1:0] angle;

    int   mismatch_count;
    int   readings_pending;
    int   samples_taken;
    int   cycle_count = 0;
    // Set for the last phase: neither side idles from then on.
    logic quiet;

    adc_spike_smooth_scale DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .despiked     (despiked),
        .smoothed     (smoothed),
        .millivolts   (millivolts),
        .angle        (angle)
    );

    adc_sss_reading_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .sample           (sample),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .despiked         (despiked),
        .smoothed         (smoothed),
        .millivolts       (millivolts),
        .angle            (angle),
        .mismatches       (mismatch_count),
        .readings_pending (readings_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Cycle watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Count sample transfers so the receiver knows when to start its long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            samples_taken <= 0;
        else if (sample_valid && sample_ready)
            samples_taken <= samples_taken + 1;
    end

    // Clamp a stimulus value into the converter code range.
    function automatic logic [SAMPLE_BITS-1:0] fit_code(int v);
        if (v < 0)
            return '0;
        if (v > CODE_MAX)
            return SAMPLE_BITS'(CODE_MAX);
        return SAMPLE_BITS'(v);
    endfunction

    function automatic int random_angle();
        return int'($urandom_range(0, 2 * ANG_LIMIT)) - ANG_LIMIT;
    endfunction

    // One register write per cycle; the caller drops the write enable after the last.
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(value);
    endtask

    task automatic program_registers(int adc_lo, int adc_hi, int thr, int mv_lo,
                                     int mv_hi, int ang_lo, int ang_hi);
        write_register(REG_ADC_LOW, adc_lo);
        write_register(REG_ADC_HIGH, adc_hi);
        write_register(REG_SPIKE_THR, thr);
        write_register(REG_MV_LOW, mv_lo);
        write_register(REG_MV_HIGH, mv_hi);
        write_register(REG_ANG_LOW, ang_lo);
        write_register(REG_ANG_HIGH, ang_hi);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Present one sample and hold it until the block takes it. Valid goes up
    // at a falling edge and the transfer is seen at a rising edge.
    task automatic offer_sample(logic [SAMPLE_BITS-1:0] code);
        @(negedge clk);
        sample_valid <= 1'b1;
        sample <= code;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    // Random sender gap, taken with a chance of one in odds.
    task automatic maybe_pause(int odds);
        int cycles;
        if (!quiet && odds != 0 && $urandom_range(1, odds) == 1)
        begin
            cycles = $urandom_range(1, 11);
            @(negedge clk);
            sample_valid <= 1'b0;
            sample <= SAMPLE_BITS'($urandom);
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every predicted reading has come back. The
    // block is idle afterwards, which is the only time registers change.
    task automatic wait_for_readings();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (readings_pending != 0)
            @(negedge clk);
    endtask

    // Register settings per phase. Besides ordinary windows this covers full
    // scale, inverted converter limits, inverted millivolt and angle spans,
    // zero spans on each map, the smallest and largest spike thresholds, and
    // a write to the unmapped index. The last phase goes back to reset values.
    task automatic configure_phase(int phase);
        int v;
        v = $urandom_range(0, CODE_MAX);
        case (phase)
            0: program_registers($urandom_range(0, 1500), $urandom_range(2500, CODE_MAX),
                                 $urandom_range(20, 400), $urandom_range(0, 3000),
                                 $urandom_range(6000, MV_MAX), -int'($urandom_range(0, 360)),
                                 $urandom_range(0, 360));
            1: program_registers(0, CODE_MAX, 0, 0, MV_MAX, -ANG_LIMIT, ANG_LIMIT);
            2: program_registers(3000, 1000, CODE_MAX, MV_MAX, 0, ANG_LIMIT, -ANG_LIMIT);
            3: program_registers(v, v, $urandom_range(0, 500), 0, MV_MAX, -ANG_LIMIT,
                                 ANG_LIMIT);
            4:
            begin
                write_register(REG_UNMAPPED, $urandom_range(0, MV_MAX));
                program_registers($urandom_range(500, 1500), $urandom_range(2500, 3500),
                                  $urandom_range(0, 300), MV_MAX, 0, ANG_LIMIT, -ANG_LIMIT);
            end
            5: program_registers(0, CODE_MAX, $urandom_range(50, 200), 7777, 7777,
                                 random_angle(), random_angle());
            6: program_registers($urandom_range(0, 1000), $urandom_range(3000, CODE_MAX),
                                 $urandom_range(1, 60), 0, MV_MAX, 123, 123);
            7: program_registers($urandom_range(0, 1500), $urandom_range(2500, CODE_MAX), 1,
                                 $urandom_range(0, MV_MAX), $urandom_range(0, MV_MAX),
                                 random_angle(), random_angle());
            9: program_registers(CODE_MAX, 0, CODE_MAX, 0, MV_MAX, -ANG_LIMIT, ANG_LIMIT);
            11: program_registers(int'(ADC_LOW_RESET), int'(ADC_HIGH_RESET),
                                  int'(SPIKE_THR_RESET), int'(MV_LOW_RESET),
                                  int'(MV_HIGH_RESET), int'(ANG_LOW_RESET),
                                  int'(ANG_HIGH_RESET));
            default: program_registers($urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
                                       $urandom_range(0, CODE_MAX), $urandom_range(0, MV_MAX),
                                       $urandom_range(0, MV_MAX), random_angle(),
                                       random_angle());
        endcase
    endtask

    // Result side. Stall odds are re-drawn whenever a window ends, so there are
    // stretches of steady acceptance as well as busy ones. Once, after enough
    // samples have gone in, the receiver holds off for a long stretch while
    // the sender keeps offering, so the block fills and stops taking samples.
    initial
    begin : receiver
        int   window;
        int   odds;
        logic long_hold_done;
        result_ready = 1'b0;
        window = 0;
        odds = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (window == 0)
            begin
                window = 64;
                case ($urandom_range(0, 2))
                    0: odds = 0;
                    1: odds = 3;
                    default: odds = 10;
                endcase
            end
            window--;
            if (!long_hold_done && samples_taken >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet && odds != 0 && $urandom_range(1, odds) == 1)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Sample side and verdict.
    initial
    begin : stimulus
        int directed_codes[$];
        int level;
        int gap_odds;
        int pick;
        logic [SAMPLE_BITS-1:0] code;

        // Directed run at reset settings (threshold 100): the first sample
        // primes the histories, a full-scale jump right after priming is an
        // isolated spike, a jump away from two unequal codes is not, a
        // difference exactly at the threshold is not a spike, one just past it
        // is, and alternating bit patterns plus both ends of the code range.
        directed_codes = {0, 4095, 4095, 4095, 2048, 2048, 2148, 2049, 1000,
                          1000, 1101, 1100, 2730, 1365, 4095, 0, 0};
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        quiet = 1'b0;
        gap_odds = 4;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_codes[i])
        begin
            offer_sample(SAMPLE_BITS'(directed_codes[i]));
            maybe_pause(gap_odds);
        end

        // Every phase starts with the sender paused until all readings are back.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_readings();
            configure_phase(phase);
            if (phase == PHASES - 1)
                quiet = 1'b1;
            level = $urandom_range(0, CODE_MAX);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 16 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0, 1: gap_odds = 0;
                        2: gap_odds = 3;
                        default: gap_odds = 8;
                    endcase
                end
                // Mostly a slowly wandering signal with small noise, so spike
                // tests see two close previous codes; some isolated spikes,
                // some level steps, and some plain noise.
                pick = $urandom_range(0, 15);
                if (pick < 2)
                begin
                    code = SAMPLE_BITS'($urandom);
                end
                else if (pick < 4)
                begin
                    if (pick == 2)
                        code = fit_code(level + int'($urandom_range(50, CODE_MAX)));
                    else
                        code = fit_code(level - int'($urandom_range(50, CODE_MAX)));
                end
                else
                begin
                    if (pick == 4)
                        level = $urandom_range(0, CODE_MAX);
                    else
                        level = int'(fit_code(level + int'($urandom_range(0, 80)) - 40));
                    code = fit_code(level + int'($urandom_range(0, 16)) - 8);
                end
                offer_sample(code);
                maybe_pause(gap_odds);
            end
        end

        wait_for_readings();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && readings_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
